// ----- hdl/md5_pkg.sv -----
// md5 digest encoder package: state enum, round constants and helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned BufAw    = 6;
  localparam int unsigned CountW   = 61;

  localparam logic [1:0] FmtRaw = 2'd0;
  localparam logic [1:0] FmtHex = 2'd1;
  localparam logic [1:0] FmtB64 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } md5_state_e;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5_rot(input logic [3:0] sel);
    logic [4:0] s;
    begin
      case (sel)
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // message word index used by each step
  function automatic logic [3:0] md5_widx(input logic [5:0] i);
    logic [3:0] g;
    begin
      case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: g = 4'(5 * i[3:0] + 1);
        2'd2: g = 4'(3 * i[3:0] + 5);
        default: g = 4'(7 * i[3:0]);
      endcase
      return g;
    end
  endfunction

  function automatic logic [7:0] md5_hex(input logic [3:0] n);
    begin
      return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h37 + 8'(n));
    end
  endfunction

  function automatic logic [7:0] md5_b64(input logic [5:0] v);
    logic [7:0] c;
    begin
      if (v < 6'd26) c = 8'h41 + 8'(v);
      else if (v < 6'd52) c = 8'h47 + 8'(v);
      else if (v < 6'd62) c = 8'(v) - 8'd4;
      else if (v == 6'd62) c = 8'h2b;
      else c = 8'h2f;
      return c;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/md5_ram.sv -----
// generic single-port write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module md5_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/md5_digest_encoder.sv -----
// md5 digest encoder top level: byte buffer, shared round unit, encoder
// depends on md5_pkg and md5_ram
// a byte that fills a block stalls input through the load, round and fold states
// last item: padding to byte 63 in one or two blocks, then one character per cycle while tready is high
// throughput: one byte per cycle inside a block; the single round adder sets the block time
// reset: chaining words to the md5 initial values, byte count zero, format raw
`timescale 1ns / 1ps
`default_nettype none
module md5_digest_encoder
  import md5_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // data_byte
  input  wire         s_axis_tuser,   // has_byte
  input  wire         s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_char
  output logic        m_axis_tlast,   // out_last
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_data_i      // output_format
);

  md5_state_e state_q, state_d;
  logic [31:0] ha_q, hb_q, hc_q, hd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [CountW-1:0] cnt_q;
  logic [1:0] fmt_q;
  logic [511:0] blk_q;       // message words for the current block
  logic [6:0] step_q;        // load byte index or round index
  logic [5:0] pad_q;         // padding write position
  logic       final_q;       // the message has ended (last item taken)
  logic       second_q;      // padding needs a second block
  logic       pad2_q;        // current padding pass is the overflow block
  logic [127:0] dig_q;
  logic [5:0] emit_q;
  logic       ld_valid_q;
  logic [5:0] ld_addr_q;

  // buffer ram
  logic       we;
  logic [5:0] waddr;
  logic [7:0] wdata;
  logic [7:0] rdata;
  md5_ram #(.Width(8), .Depth(BufDepth)) u_buf (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(step_q[5:0]), .rdata_o(rdata)
  );

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // shared round unit
  logic [31:0] f, x, rot, wsel;
  logic [4:0]  s;
  always_comb begin
    case (step_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    wsel = blk_q[32*md5_widx(step_q[5:0]) +: 32];
    s = md5_rot({step_q[5:4], step_q[1:0]});
    x = a_q + f + md5_k(step_q[5:0]) + wsel;
    rot = (x << s) | (x >> (6'd32 - {1'b0, s}));
  end

  // padding byte: 0x80 at end of message, zeros, then length
  logic [63:0] bits;
  logic [7:0]  padbyte;
  logic [5:0]  pidx;
  assign bits = {cnt_q, 3'b000};
  assign pidx = cnt_q[5:0];
  always_comb begin
    if (pad_q == pidx && !pad2_q) padbyte = 8'h80;
    else if (pad_q >= 6'd56 && (pad2_q || pidx < 6'd56))
      padbyte = bits[8*pad_q[2:0] +: 8];
    else padbyte = 8'h00;
  end

  // encoder character
  logic [7:0] ch;
  logic [5:0] nchars;
  logic [6:0] bpos;
  logic [15:0] pair;
  logic [135:0] digx;
  logic [3:0] nib;
  logic [4:0] bi;
  always_comb begin
    digx = {8'h00, dig_q};
    bpos = 7'(6 * emit_q);
    bi = {1'b0, bpos[6:3]};
    pair = {digx[8*bi +: 8], digx[8*(bi+5'd1) +: 8]};
    nib = emit_q[0] ? dig_q[8*emit_q[4:1] +: 4] : dig_q[8*emit_q[4:1] + 4 +: 4];
    case (fmt_q)
      FmtRaw: begin ch = dig_q[8*emit_q[3:0] +: 8]; nchars = 6'd16; end
      FmtHex: begin ch = md5_hex(nib); nchars = 6'd32; end
      FmtB64: begin
        ch = md5_b64(6'(pair >> (4'd10 - {1'b0, bpos[2:0]})));
        nchars = 6'd22;
      end
      default: begin ch = 8'h00; nchars = 6'd0; end
    endcase
  end

  // next state and buffer write
  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = cnt_q[5:0];
    wdata = s_axis_tdata;
    case (state_q)
      ST_IDLE: if (acc) begin
        we = s_axis_tuser;
        if (s_axis_tuser && cnt_q[5:0] == 6'd63) state_d = ST_LOAD;
        else if (s_axis_tlast) state_d = ST_PAD;
      end
      ST_PAD: begin
        we = 1'b1; waddr = pad_q; wdata = padbyte;
        if (pad_q == 6'd63) state_d = ST_LOAD;
      end
      ST_LOAD: if (ld_valid_q && ld_addr_q == 6'd63) state_d = ST_ROUND;
      ST_ROUND: if (step_q[5:0] == 6'd63) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!final_q) state_d = ST_IDLE;
        else if (second_q) state_d = ST_PAD;
        else if (nchars == 6'd0) state_d = ST_IDLE;
        else state_d = ST_EMIT;
      end
      ST_EMIT: if (m_axis_tready && emit_q == nchars - 6'd1) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata = ch;
  assign m_axis_tlast = (emit_q == nchars - 6'd1);

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ha_q <= InitA; hb_q <= InitB; hc_q <= InitC; hd_q <= InitD;
      cnt_q <= '0; fmt_q <= FmtRaw;
      step_q <= '0; pad_q <= '0; final_q <= 1'b0; second_q <= 1'b0;
      emit_q <= '0; ld_valid_q <= 1'b0; ld_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) fmt_q <= cfg_data_i;
      ld_valid_q <= (state_q == ST_LOAD) && !step_q[6];
      case (state_q)
        ST_IDLE: if (acc) begin
          if (s_axis_tuser) cnt_q <= cnt_q + 1'b1;
          final_q <= s_axis_tlast;
          step_q <= '0;
          // a full block: when the message ends here, pad a fresh block after it
          if (s_axis_tuser && cnt_q[5:0] == 6'd63) begin
            second_q <= s_axis_tlast;
            pad_q <= '0;
          end else if (s_axis_tlast) begin
            pad_q <= s_axis_tuser ? cnt_q[5:0] + 6'd1 : cnt_q[5:0];
            second_q <= 1'b0;
          end
        end
        ST_PAD: begin
          pad_q <= pad_q + 1'b1;
          if (pad_q == 6'd63) begin
            step_q <= '0;
            // the length no longer fits behind the 0x80 marker
            second_q <= !pad2_q && (pidx >= 6'd56);
          end
        end
        ST_LOAD: begin
          ld_addr_q <= step_q[5:0];
          if (ld_valid_q) blk_q[8*ld_addr_q +: 8] <= rdata;
          if (ld_valid_q && ld_addr_q == 6'd63) begin
            step_q <= '0;
            a_q <= ha_q; b_q <= hb_q; c_q <= hc_q; d_q <= hd_q;
          end else if (step_q[6] == 1'b0) begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_ROUND: begin
          a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
          step_q <= step_q + 1'b1;
        end
        ST_FOLD: begin
          dig_q <= {hd_q + d_q, hc_q + c_q, hb_q + b_q, ha_q + a_q};
          emit_q <= '0;
          if (final_q && !second_q) begin
            ha_q <= InitA; hb_q <= InitB; hc_q <= InitC; hd_q <= InitD;
            cnt_q <= '0;
          end else begin
            ha_q <= ha_q + a_q; hb_q <= hb_q + b_q;
            hc_q <= hc_q + c_q; hd_q <= hd_q + d_q;
          end
          // another padding block follows
          if (final_q && second_q) begin
            second_q <= 1'b0;
            pad_q <= '0;
          end
        end
        ST_EMIT: if (m_axis_tready) emit_q <= emit_q + 1'b1;
        default: ;
      endcase
    end
  end

  // overflow padding block: no marker, length in the last eight bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad2_q <= 1'b0;
    else if (state_q == ST_IDLE) pad2_q <= 1'b0;
    else if (state_q == ST_PAD && pad_q == 6'd63) pad2_q <= !pad2_q && (pidx >= 6'd56);
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> !s_axis_tready) else $error("ready during rounds");
  a_round_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && step_q[5:0] != 6'd63) |=> (state_q == ST_ROUND))
    else $error("round sequence broken");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(emit_q)) else $error("emit moved");
  a_pad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad2_q |-> !(state_q == ST_EMIT)) else $error("pad flag while emitting");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_md5_digest_encoder.sv -----
// testbench for the md5 digest encoder: directed table, padding-boundary messages, then random messages,
// every digest character checked against an in-bench md5 predictor
// depends on md5_pkg and md5_digest_encoder
`timescale 1ns / 1ps
`default_nettype none
module tb_md5_digest_encoder;
  import md5_pkg::*;

  localparam int unsigned TimeoutCycles = 20000;
  localparam int unsigned DrainCycles   = 400;
  localparam int unsigned MaxErrors     = 50;
  localparam logic [1:0]  FmtUnused     = 2'd3;

  // one row of the directed stimulus table
  typedef struct {
    logic       cfg_write;
    logic [1:0] fmt;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    logic [7:0] first_char;  // expected first digest character
    logic       check_first;
  } stim_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
  } digest_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  wire        s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       s_axis_tlast = 1'b0;
  wire        m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  wire  [7:0] m_axis_tdata;
  wire        m_axis_tlast;
  logic       cfg_valid_i = 1'b0;
  wire        cfg_ready_o;
  logic [1:0] cfg_data_i = '0;

  // predictor state
  logic [31:0] hash_a, hash_b, hash_c, hash_d;
  logic [7:0]  msg_block [64];
  logic [60:0] msg_len;
  logic [1:0]  digest_fmt;

  digest_char_t expected_chars[$];
  logic [7:0]   first_checks[$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  logic         rx_idle_enable = 1'b1;

  md5_digest_encoder DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] round_const(input int i);
    return 32'(longint'($floor($pow(2.0, 32.0) * (($sin(i + 1.0) < 0) ?
      -$sin(i + 1.0) : $sin(i + 1.0)))));
  endfunction

  // chaining words back to the md5 start values, block and length cleared
  task automatic hash_restart();
    hash_a = 32'h67452301; hash_b = 32'hefcdab89;
    hash_c = 32'h98badcfe; hash_d = 32'h10325476;
    foreach (msg_block[i]) msg_block[i] = '0;
    msg_len = '0;
  endtask

  task automatic hash_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, x, t;
    int g, s;
    int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    a = hash_a; b = hash_b; c = hash_c; d = hash_d;
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      s = shifts[(i / 16) * 4 + i % 4];
      x = a + f + round_const(i) + w[g];
      t = d; d = c; c = b;
      b = b + ((x << s) | (x >> (32 - s)));
      a = t;
    end
    hash_a += a; hash_b += b; hash_c += c; hash_d += d;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v) - 8'd26;
    if (v < 62) return 8'h30 + 8'(v) - 8'd52;
    return (v == 62) ? 8'h2b : 8'h2f;
  endfunction

  // pad, compress the tail, queue the encoded digest and restart the predictor
  task automatic hash_finish();
    logic [7:0]  dig [17];
    logic [63:0] bits;
    logic [15:0] pair;
    int idx, n0, nbyte, off;
    idx = int'(msg_len[5:0]);
    bits = {msg_len, 3'b000};
    msg_block[idx++] = 8'h80;
    if (idx > 56) begin
      for (int i = idx; i < 64; i++) msg_block[i] = '0;
      hash_compress();
      idx = 0;
    end
    for (int i = idx; i < 56; i++) msg_block[i] = '0;
    for (int i = 0; i < 8; i++) msg_block[56 + i] = bits[8*i +: 8];
    hash_compress();
    for (int i = 0; i < 4; i++) begin
      dig[i] = hash_a[8*i +: 8]; dig[4+i] = hash_b[8*i +: 8];
      dig[8+i] = hash_c[8*i +: 8]; dig[12+i] = hash_d[8*i +: 8];
    end
    dig[16] = '0;
    n0 = expected_chars.size();
    case (digest_fmt)
      FmtRaw: for (int i = 0; i < 16; i++) expected_chars.push_back('{dig[i], 1'b0});
      FmtHex: for (int i = 0; i < 16; i++) begin
        expected_chars.push_back('{hex_char(dig[i][7:4]), 1'b0});
        expected_chars.push_back('{hex_char(dig[i][3:0]), 1'b0});
      end
      FmtB64: for (int i = 0; i < 22; i++) begin
        nbyte = (6 * i) / 8; off = (6 * i) % 8;
        pair = {dig[nbyte], dig[nbyte + 1]};
        expected_chars.push_back('{b64_char(6'(pair >> (10 - off))), 1'b0});
      end
      default: ;
    endcase
    if (expected_chars.size() > n0) expected_chars[$].lst = 1'b1;
    hash_restart();
  endtask

  task automatic hash_step(input logic [7:0] db, input logic hb, input logic lst);
    if (hb) begin
      msg_block[msg_len[5:0]] = db;
      msg_len = msg_len + 1'b1;
      if (msg_len[5:0] == 0) hash_compress();
    end
    if (lst) hash_finish();
  endtask

  // one input transaction, gaps at random unless disabled; returns at a falling edge
  task automatic send_item(input logic [7:0] db, input logic hb, input logic lst,
                           input logic gaps);
    while (gaps && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= db;
    s_axis_tuser  <= hb;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hash_step(db, hb, lst);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every expected character
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // write the format register once the block is quiet
  task automatic set_format(input logic [1:0] fmt);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_chars.size() != 0 || !s_axis_tready) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    digest_fmt = fmt;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stalls at random while rx_idle_enable is set
  always @(negedge clk_i)
    m_axis_tready <= !rx_idle_enable || ($urandom_range(99) >= 22);

  // result check and watchdog
  always @(posedge clk_i) begin
    digest_char_t exp_c;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char expected none actual %h/%b", $time,
                   m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (m_axis_tdata !== exp_c.ch || m_axis_tlast !== exp_c.lst) begin
            $display("%0t: char mismatch expected %h/%b actual %h/%b", $time,
                     exp_c.ch, exp_c.lst, m_axis_tdata, m_axis_tlast);
            error_count++;
          end
          if (first_checks.size() != 0 && m_axis_tdata !== first_checks[0]) begin
            $display("%0t: first char expected %h actual %h", $time,
                     first_checks[0], m_axis_tdata);
            error_count++;
          end
          if (first_checks.size() != 0) void'(first_checks.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= TimeoutCycles || error_count >= MaxErrors) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // directed table: the empty-message digest starts with d4 raw, D hex, 1 base64
  stim_row_t directed [12] = '{
    '{1'b0, FmtRaw,    8'h00, 1'b0, 1'b1, 8'hd4, 1'b1},
    '{1'b0, FmtRaw,    8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{1'b0, FmtRaw,    8'h61, 1'b1, 1'b1, 8'h0c, 1'b1},
    '{1'b1, FmtHex,    8'h00, 1'b0, 1'b1, 8'h44, 1'b1},
    '{1'b0, FmtHex,    8'hff, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, FmtHex,    8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
    '{1'b1, FmtB64,    8'h00, 1'b0, 1'b1, 8'h31, 1'b1},
    '{1'b0, FmtB64,    8'haa, 1'b1, 1'b0, 8'h00, 1'b0},
    '{1'b0, FmtB64,    8'h55, 1'b1, 1'b1, 8'h00, 1'b0},
    '{1'b1, FmtUnused, 8'h12, 1'b1, 1'b1, 8'h00, 1'b0},
    '{1'b0, FmtUnused, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
    '{1'b1, FmtRaw,    8'h80, 1'b1, 1'b1, 8'h00, 1'b0}
  };

  initial begin
    int len, nsent, fmt_pick;
    logic gaps;
    hash_restart();
    digest_fmt = FmtRaw;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[r]) begin
      if (directed[r].cfg_write) set_format(directed[r].fmt);
      if (directed[r].check_first) begin
        wait_drain();
        first_checks.delete();
        first_checks.push_back(directed[r].first_char);
      end
      send_item(directed[r].data_byte, directed[r].has_byte, directed[r].last, 1'b1);
    end

    // messages crossing the padding boundaries: 55, 56, 63, 64 bytes
    for (int k = 0; k < 4; k++) begin
      len = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : 64;
      for (int i = 0; i < len; i++)
        send_item(8'($urandom), 1'b1, i == len - 1, 1'b1);
    end
    wait_drain();

    // random messages, with a gap-free stretch and a format change now and then
    nsent = 0;
    while (nsent < 200) begin
      if ($urandom_range(5) == 0) begin
        fmt_pick = $urandom_range(3);
        set_format(2'(fmt_pick));
      end
      gaps = !(nsent > 60 && nsent < 140);
      rx_idle_enable = gaps;
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 140) : $urandom_range(0, 20);
      if (len > 210 - nsent) len = 210 - nsent;
      for (int i = 0; i <= len; i++) begin
        if ($urandom_range(9) == 0 && i != len) begin
          send_item(8'($urandom), 1'b0, 1'b0, gaps);
          nsent++;
        end
        send_item(8'($urandom), i != len || $urandom_range(1) == 1, i == len, gaps);
        nsent++;
      end
      // now and then hold the sender until all characters are back
      if ($urandom_range(7) == 0) wait_drain();
    end
    set_format(FmtHex);
    send_item(8'h00, 1'b0, 1'b1, 1'b1);

    rx_idle_enable = 1'b1;
    wait_drain();
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/md5_pkg.sv
hdl/md5_ram.sv
hdl/md5_digest_encoder.sv
tb/sv/tb_md5_digest_encoder.sv
